// ----- design/ypc_pkg.sv -----
// Shared types, constants and helper functions for the yaw/pitch camera pose block.
// Depends on nothing; used by ypc_cordic, ypc_mul and yaw_pitch_camera_pose_top.
`default_nettype none
package ypc_pkg;

	localparam int VW = 52;	// CORDIC x/y datapath width
	localparam int ZW = 34;	// CORDIC angle accumulator width
	localparam int TW = 36;	// trig value and multiplier operand width

	localparam logic [2:0] CMD_SET_POS  = 3'd0;
	localparam logic [2:0] CMD_SET_TGT  = 3'd1;
	localparam logic [2:0] CMD_MOVE_FWD = 3'd2;
	localparam logic [2:0] CMD_MOVE_RGT = 3'd3;
	localparam logic [2:0] CMD_MOVE_UP  = 3'd4;
	localparam logic [2:0] CMD_ROTATE   = 3'd5;

	localparam logic signed [ZW-1:0] QUARTER_Z   = 34'sd1073741824;
	localparam logic signed [ZW-1:0] HALF_Z      = 34'sd2147483648;
	localparam logic signed [32:0]   PITCH_LIMIT = 33'sd1066906172;
	localparam logic [31:0]          PITCH_UP    = 32'h4000_0000;
	localparam logic [31:0]          PITCH_DOWN  = 32'hC000_0000;
	localparam logic signed [TW-1:0] CORDIC_GAIN = 36'sd652032874;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [31:0] distance;
		logic signed [31:0] yaw_delta;
		logic signed [31:0] pitch_delta;
	} ypc_in_t;

	typedef struct packed {
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic [31:0]        out_yaw;
		logic signed [31:0] out_pitch;
		logic signed [15:0] forward_x;
		logic signed [15:0] forward_y;
		logic signed [15:0] forward_z;
	} ypc_out_t;

	typedef struct packed {
		logic start;
		logic vec_mode;	// 1: vectoring (angle of x,y), 0: rotation (sin/cos)
	} ypc_cordic_req_t;

	// atan(2^-i) in binary angle units, 2^32 per turn
	function automatic logic [29:0] atan_lut(input logic [4:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670163;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Q2.30 to Q2.14, round half up, clamp to +-1.0
	function automatic logic signed [15:0] to_q14(input logic signed [TW-1:0] v);
		logic signed [TW:0] s;
		logic signed [15:0] r;
		s = ($signed({v[TW-1], v}) + 37'sd32768) >>> 16;
		if (s > 37'sd16384)
			r = 16'sd16384;
		else if (s < -37'sd16384)
			r = -16'sd16384;
		else
			r = s[15:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/ypc_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on ypc_pkg for the operand width.
`default_nettype none
module ypc_mul (
	input  wire logic                                clk,
	input  wire logic signed [ypc_pkg::TW-1:0]       a,
	input  wire logic signed [ypc_pkg::TW-1:0]       b,
	output logic signed      [2*ypc_pkg::TW-1:0]     p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

// ----- design/ypc_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, rotation and vectoring modes.
// Depends on ypc_pkg for widths, gain, arctangent table and request type.
`default_nettype none
module ypc_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ypc_pkg::ypc_cordic_req_t         req,
	input  wire logic signed [ypc_pkg::VW-1:0]    x_in,
	input  wire logic signed [ypc_pkg::VW-1:0]    y_in,
	input  wire logic [31:0]                      ang_in,
	output logic                                  busy,
	output logic                                  done,
	output logic signed [ypc_pkg::VW-1:0]         x_out,
	output logic signed [ypc_pkg::VW-1:0]         y_out,
	output logic signed [ypc_pkg::ZW-1:0]         z_out
);
	localparam int VW = ypc_pkg::VW;
	localparam int ZW = ypc_pkg::ZW;
	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic signed [VW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0]        i_q;
	logic                 busy_q, done_q, vec_q, flip_q;

	logic signed [VW-1:0] xs, ys;
	logic signed [ZW-1:0] at;
	logic                 dirp;
	logic signed [ZW-1:0] a0;

	always_comb begin
		xs   = x_q >>> i_q;
		ys   = y_q >>> i_q;
		at   = $signed({{(ZW-30){1'b0}}, ypc_pkg::atan_lut(5'(i_q))});
		dirp = vec_q ? (y_q <= 0) : (z_q >= 0);
		a0   = $signed({{(ZW-32){ang_in[31]}}, ang_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			vec_q  <= 1'b0;
			flip_q <= 1'b0;
		end else begin
			done_q <= busy_q && (i_q == IW'(STEPS - 1));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				vec_q  <= req.vec_mode;
				flip_q <= !req.vec_mode
					&& (a0 > ypc_pkg::QUARTER_Z || a0 < -ypc_pkg::QUARTER_Z);
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			if (req.vec_mode) begin
				if (x_in < 0) begin
					if (y_in >= 0) begin
						x_q <= y_in;
						y_q <= -x_in;
						z_q <= ypc_pkg::QUARTER_Z;
					end else begin
						x_q <= -y_in;
						y_q <= x_in;
						z_q <= -ypc_pkg::QUARTER_Z;
					end
				end else begin
					x_q <= x_in;
					y_q <= y_in;
					z_q <= '0;
				end
			end else begin
				x_q <= VW'(ypc_pkg::CORDIC_GAIN);
				y_q <= '0;
				if (a0 > ypc_pkg::QUARTER_Z)
					z_q <= a0 - ypc_pkg::HALF_Z;
				else if (a0 < -ypc_pkg::QUARTER_Z)
					z_q <= a0 + ypc_pkg::HALF_Z;
				else
					z_q <= a0;
			end
		end else if (busy_q) begin
			if (dirp) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign x_out = flip_q ? -x_q : x_q;
	assign y_out = flip_q ? -y_q : y_q;
	assign z_out = z_q;
endmodule
`default_nettype wire

// ----- design/yaw_pitch_camera_pose_top.sv -----
// Top level of the yaw/pitch camera pose block: sequencer, pose state, output register.
// Depends on ypc_pkg, ypc_cordic and ypc_mul.
`default_nettype none
// The block keeps a camera position (Q16.16) and a yaw and pitch (binary angles,
// 2^32 per turn) and takes one command per input transaction: set position, aim
// at a target, move forward, move right, move up, or rotate. Each transaction
// returns one output transaction with the new pose and the forward vector in
// Q2.14. All arithmetic runs through one iterative CORDIC (one micro-rotation
// per cycle, CORDIC_STEPS micro-rotations a run) and one registered 36x36
// multiplier under a small sequencer; in_ready is high only while the
// sequencer is idle. The sines and cosines of the current angles are cached,
// so a command that leaves the angles alone (set position, move up, move
// right, move forward) costs no CORDIC run, only multiplier work. Rotate
// spends two CORDIC runs to refresh the cache, set target up to two vectoring
// runs and then two more for the cache. The first transaction after reset also
// fills the cache. The output register lets the next transaction start while a
// result is still waiting to be taken.
module yaw_pitch_camera_pose_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ypc_pkg::ypc_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ypc_pkg::ypc_out_t      out_data
);
	localparam int VW = ypc_pkg::VW;
	localparam int ZW = ypc_pkg::ZW;
	localparam int TW = ypc_pkg::TW;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;	// refresh trig cache if stale
	localparam logic [3:0] S_TRY  = 4'd2;	// CORDIC on yaw
	localparam logic [3:0] S_TRP  = 4'd3;	// CORDIC on pitch
	localparam logic [3:0] S_EXEC = 4'd4;	// apply the command
	localparam logic [3:0] S_AIMY = 4'd5;	// vectoring for yaw
	localparam logic [3:0] S_AIMP = 4'd6;	// vectoring for pitch
	localparam logic [3:0] S_MUL  = 4'd7;	// multiplier issue
	localparam logic [3:0] S_ACC  = 4'd8;	// multiplier result use
	localparam logic [3:0] S_OUT  = 4'd9;

	// multiplier operations
	localparam logic [2:0] U_FX = 3'd0;
	localparam logic [2:0] U_FZ = 3'd1;
	localparam logic [2:0] U_MX = 3'd2;
	localparam logic [2:0] U_MY = 3'd3;
	localparam logic [2:0] U_MZ = 3'd4;
	localparam logic [2:0] U_H1 = 3'd5;
	localparam logic [2:0] U_H2 = 3'd6;

	logic [3:0]         state_q;
	logic [2:0]         uop_q;
	logic               post_q, trig_ok_q, out_valid_q;
	ypc_pkg::ypc_in_t   item_q;
	ypc_pkg::ypc_out_t  out_q;
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [31:0]        yaw_q, pitch_q;
	logic signed [TW-1:0] cy_q, sy_q, cp_q, sp_q, fx_q, fz_q;
	logic signed [VW-1:0] m_q, hacc_q;

	// CORDIC and multiplier hookup
	ypc_pkg::ypc_cordic_req_t cord_req;
	logic signed [VW-1:0] cord_x_in, cord_y_in, cord_x, cord_y;
	logic [31:0]          cord_ang;
	logic signed [ZW-1:0] cord_z;
	logic                 cord_busy, cord_done;
	logic signed [TW-1:0] opa, opb;
	logic signed [2*TW-1:0] prod;

	ypc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cord_req),
		.x_in   (cord_x_in),
		.y_in   (cord_y_in),
		.ang_in (cord_ang),
		.busy   (cord_busy),
		.done   (cord_done),
		.x_out  (cord_x),
		.y_out  (cord_y),
		.z_out  (cord_z)
	);

	ypc_mul u_mul (
		.clk (clk),
		.a   (opa),
		.b   (opb),
		.p_q (prod)
	);

	// target direction relative to the camera
	logic signed [32:0]   dx, dy, dz;
	logic signed [VW-1:0] dx_s, dy_s, dz_s, h_val;
	logic signed [TW-1:0] dist_t;
	logic signed [2*TW-1:0] prod_rnd;
	logic signed [33:0]   move_d, sum_x, sum_y, sum_z;
	logic signed [32:0]   pitch_sum;
	logic                 dir_zero, flat_zero, pitch_vert;

	always_comb begin
		dx        = $signed({item_q.coord_x[31], item_q.coord_x}) - $signed({cam_x_q[31], cam_x_q});
		dy        = $signed({item_q.coord_y[31], item_q.coord_y}) - $signed({cam_y_q[31], cam_y_q});
		dz        = $signed({item_q.coord_z[31], item_q.coord_z}) - $signed({cam_z_q[31], cam_z_q});
		dx_s      = $signed({{(VW-49){dx[32]}}, dx, 16'h0000});
		dy_s      = $signed({{(VW-49){dy[32]}}, dy, 16'h0000});
		dz_s      = $signed({{(VW-49){dz[32]}}, dz, 16'h0000});
		dir_zero  = (dx == 0) && (dy == 0) && (dz == 0);
		flat_zero = (dx == 0) && (dz == 0);
		pitch_vert = (pitch_q == ypc_pkg::PITCH_UP) || (pitch_q == ypc_pkg::PITCH_DOWN);
		dist_t    = $signed({{(TW-32){item_q.distance[31]}}, item_q.distance});
		// round half up from Q16.46 to Q16.16
		prod_rnd  = (prod + 72'sd536870912) >>> 30;
		move_d    = prod_rnd[33:0];
		sum_x     = $signed({{2{cam_x_q[31]}}, cam_x_q}) + move_d;
		sum_y     = $signed({{2{cam_y_q[31]}}, cam_y_q}) + move_d;
		sum_z     = $signed({{2{cam_z_q[31]}}, cam_z_q}) + move_d;
		h_val     = hacc_q + VW'(prod >>> 30);
		pitch_sum = $signed({pitch_q[31], pitch_q})
			+ $signed({item_q.pitch_delta[31], item_q.pitch_delta});
	end

	// multiplier operand select
	always_comb begin
		opa = sy_q;
		opb = cp_q;
		case (uop_q)
			U_FX: begin opa = sy_q; opb = cp_q; end
			U_FZ: begin opa = cy_q; opb = cp_q; end
			U_MX: begin
				opa = dist_t;
				opb = (item_q.command == ypc_pkg::CMD_MOVE_RGT) ? cy_q : fx_q;
			end
			U_MY: begin opa = dist_t; opb = sp_q; end
			U_MZ: begin
				opa = dist_t;
				opb = (item_q.command == ypc_pkg::CMD_MOVE_RGT) ? -sy_q : fz_q;
			end
			U_H1: begin opa = TW'(m_q >>> 30); opb = ypc_pkg::CORDIC_GAIN; end
			U_H2: begin
				opa = $signed({{(TW-30){1'b0}}, m_q[29:0]});
				opb = ypc_pkg::CORDIC_GAIN;
			end
			default: begin opa = sy_q; opb = cp_q; end
		endcase
	end

	// CORDIC launch: yaw/pitch rotations and the two vectoring runs of set target
	always_comb begin
		cord_req.start    = 1'b0;
		cord_req.vec_mode = 1'b0;
		cord_x_in         = dz_s;
		cord_y_in         = dx_s;
		cord_ang          = yaw_q;
		case (state_q)
			S_CHK: cord_req.start = !trig_ok_q;
			S_TRY: begin
				cord_req.start = cord_done;
				cord_ang       = pitch_q;
			end
			S_EXEC: begin
				cord_req.start    = (item_q.command == ypc_pkg::CMD_SET_TGT) && !flat_zero;
				cord_req.vec_mode = 1'b1;
			end
			S_ACC: begin
				cord_req.start    = (uop_q == U_H2) && (h_val > 0);
				cord_req.vec_mode = 1'b1;
				cord_x_in         = h_val;
				cord_y_in         = dy_s;
			end
			default: cord_req.start = 1'b0;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			uop_q       <= U_FX;
			post_q      <= 1'b0;
			trig_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
			cam_x_q     <= '0;
			cam_y_q     <= '0;
			cam_z_q     <= '0;
			yaw_q       <= '0;
			pitch_q     <= '0;
		end else begin
			// drop the result once taken, unless a new one is loaded this cycle
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						post_q  <= 1'b0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!trig_ok_q) begin
						state_q <= S_TRY;
					end else if (post_q) begin
						uop_q   <= U_FX;
						state_q <= S_MUL;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_TRY: begin
					if (cord_done)
						state_q <= S_TRP;
				end
				S_TRP: begin
					if (cord_done) begin
						trig_ok_q <= 1'b1;
						if (post_q) begin
							uop_q   <= U_FX;
							state_q <= S_MUL;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					case (item_q.command)
						ypc_pkg::CMD_SET_POS: begin
							cam_x_q <= item_q.coord_x;
							cam_y_q <= item_q.coord_y;
							cam_z_q <= item_q.coord_z;
							post_q  <= 1'b1;
							state_q <= S_CHK;
						end
						ypc_pkg::CMD_SET_TGT: begin
							trig_ok_q <= 1'b0;
							if (dir_zero) begin
								yaw_q   <= '0;
								pitch_q <= '0;
								post_q  <= 1'b1;
								state_q <= S_CHK;
							end else if (flat_zero) begin
								yaw_q   <= '0;
								pitch_q <= (dy > 0) ? ypc_pkg::PITCH_UP : ypc_pkg::PITCH_DOWN;
								post_q  <= 1'b1;
								state_q <= S_CHK;
							end else begin
								post_q  <= 1'b0;
								state_q <= S_AIMY;
							end
						end
						ypc_pkg::CMD_MOVE_FWD: begin
							post_q  <= 1'b0;
							uop_q   <= U_FX;
							state_q <= S_MUL;
						end
						ypc_pkg::CMD_MOVE_RGT: begin
							// no right vector while looking straight up or down
							if (!pitch_vert) begin
								post_q  <= 1'b0;
								uop_q   <= U_MX;
								state_q <= S_MUL;
							end else begin
								post_q  <= 1'b1;
								state_q <= S_CHK;
							end
						end
						ypc_pkg::CMD_MOVE_UP: begin
							cam_y_q <= ypc_pkg::sat32($signed({{2{cam_y_q[31]}}, cam_y_q})
								+ $signed({{2{item_q.distance[31]}}, item_q.distance}));
							post_q  <= 1'b1;
							state_q <= S_CHK;
						end
						ypc_pkg::CMD_ROTATE: begin
							trig_ok_q <= 1'b0;
							yaw_q     <= yaw_q + item_q.yaw_delta;
							if (pitch_sum > ypc_pkg::PITCH_LIMIT)
								pitch_q <= ypc_pkg::PITCH_LIMIT[31:0];
							else if (pitch_sum < -ypc_pkg::PITCH_LIMIT)
								pitch_q <= 32'(-ypc_pkg::PITCH_LIMIT);
							else
								pitch_q <= pitch_sum[31:0];
							post_q  <= 1'b1;
							state_q <= S_CHK;
						end
						default: begin
							post_q  <= 1'b1;
							state_q <= S_CHK;
						end
					endcase
				end
				S_AIMY: begin
					if (cord_done) begin
						yaw_q   <= cord_z[31:0];
						uop_q   <= U_H1;
						state_q <= S_MUL;
					end
				end
				S_AIMP: begin
					if (cord_done) begin
						if (cord_z > ypc_pkg::QUARTER_Z)
							pitch_q <= ypc_pkg::PITCH_UP;
						else if (cord_z < -ypc_pkg::QUARTER_Z)
							pitch_q <= ypc_pkg::PITCH_DOWN;
						else
							pitch_q <= cord_z[31:0];
						post_q  <= 1'b1;
						state_q <= S_CHK;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					case (uop_q)
						U_FX: begin
							uop_q   <= U_FZ;
							state_q <= S_MUL;
						end
						U_FZ: begin
							if (post_q) begin
								state_q <= S_OUT;
							end else begin
								uop_q   <= U_MX;
								state_q <= S_MUL;
							end
						end
						U_MX: begin
							cam_x_q <= ypc_pkg::sat32(sum_x);
							uop_q   <= (item_q.command == ypc_pkg::CMD_MOVE_RGT) ? U_MZ : U_MY;
							state_q <= S_MUL;
						end
						U_MY: begin
							cam_y_q <= ypc_pkg::sat32(sum_y);
							uop_q   <= U_MZ;
							state_q <= S_MUL;
						end
						U_MZ: begin
							cam_z_q <= ypc_pkg::sat32(sum_z);
							post_q  <= 1'b1;
							state_q <= S_CHK;
						end
						U_H1: begin
							uop_q   <= U_H2;
							state_q <= S_MUL;
						end
						U_H2: begin
							if (h_val > 0) begin
								state_q <= S_AIMP;
							end else begin
								pitch_q <= (dy > 0) ? ypc_pkg::PITCH_UP : ypc_pkg::PITCH_DOWN;
								post_q  <= 1'b1;
								state_q <= S_CHK;
							end
						end
						default: state_q <= S_CHK;
					endcase
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			item_q <= in_data;
		if ((state_q == S_TRY) && cord_done) begin
			cy_q <= cord_x[TW-1:0];
			sy_q <= cord_y[TW-1:0];
		end
		if ((state_q == S_TRP) && cord_done) begin
			cp_q <= cord_x[TW-1:0];
			sp_q <= cord_y[TW-1:0];
		end
		if ((state_q == S_AIMY) && cord_done)
			m_q <= cord_x;
		if (state_q == S_ACC) begin
			if (uop_q == U_FX)
				fx_q <= TW'(prod >>> 30);
			if (uop_q == U_FZ)
				fz_q <= TW'(prod >>> 30);
			if (uop_q == U_H1)
				hacc_q <= prod[VW-1:0];
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.out_pos_x <= cam_x_q;
			out_q.out_pos_y <= cam_y_q;
			out_q.out_pos_z <= cam_z_q;
			out_q.out_yaw   <= yaw_q;
			out_q.out_pitch <= pitch_q;
			out_q.forward_x <= ypc_pkg::to_q14(fx_q);
			out_q.forward_y <= ypc_pkg::to_q14(sp_q);
			out_q.forward_z <= ypc_pkg::to_q14(fz_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The CORDIC must be free whenever a new transaction may enter.
	a_idle_cordic_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cord_busy)
		else $error("CORDIC busy while sequencer idle");

	// A finished result is loaded at once when the output register is empty.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_valid_q) |=> out_valid_q)
		else $error("result not loaded into empty output register");

	// CORDIC completions only arrive in states that wait for them.
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> (state_q == S_TRY || state_q == S_TRP
			|| state_q == S_AIMY || state_q == S_AIMP))
		else $error("CORDIC done in unexpected state");

	// Pitch never leaves a quarter turn either way.
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		($signed(pitch_q) <= 32'sd1073741824) && ($signed(pitch_q) >= -32'sd1073741824))
		else $error("pitch out of range");

endmodule
`default_nettype wire
